### rtl/cdet_pkg.sv
// ----------------------------------------------------------------------------
// cdet_pkg
// Shared types and codes for the coalescing delay event table.
// ----------------------------------------------------------------------------
package cdet_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] KIND_APPENDED = 3'd0;
    localparam logic [2:0] KIND_MERGED   = 3'd1;
    localparam logic [2:0] KIND_DROPPED  = 3'd2;
    localparam logic [2:0] KIND_EXPIRED  = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;
    localparam logic [2:0] KIND_CLEARED  = 3'd5;

    // One table entry as stored in memory
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] rem;
        logic [15:0] flags;
    } entry_t;

endpackage

### rtl/cdet_mem.sv
// ----------------------------------------------------------------------------
// cdet_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cdet_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  cdet_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output cdet_pkg::entry_t rdata
);

    cdet_pkg::entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/coalescing_delay_event_table.sv
// Insert walks the entries with one memory read per entry, stopping at a key
// match, plus at most one write; tick walks every entry; clear needs no walk.
// Requests are taken one at a time; busy drops when the last word is driven.
// The walk over the entry memory sets how long a request keeps busy high.
// Reset clears occupancy and control; memory contents need no clearing.
// Result words appear on strobe for one cycle; the receiver cannot stall.
module coalescing_delay_event_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        delay_ticks,
    input  logic [15:0]        event_flags,
    output logic               strobe,
    output logic [2:0]         res_kind,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [15:0]        out_flags,
    output logic               last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [1:0]       op_reg;
    logic [CW-1:0]    occ_reg;
    logic [CW-1:0]    rd_reg;      // next address to read
    logic [CW-1:0]    kept_reg;    // tick compaction write pointer
    logic             rvalid_reg;  // read data valid this cycle
    logic [AW-1:0]    raddr_last_reg;
    logic             emitted_reg; // tick emitted anything
    logic             hit_reg;
    cdet_pkg::entry_t req_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    cdet_pkg::entry_t wdata;
    cdet_pkg::entry_t rdata;
    logic [AW-1:0]    raddr;

    // Pending expired word: hold one so last can be set on the final one
    logic             pend_reg;
    cdet_pkg::entry_t pend_data_reg;

    cdet_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr = rd_reg[AW-1:0];
    assign busy  = (state_reg != ST_IDLE);

    logic key_eq;
    assign key_eq = (rdata.x == req_reg.x) && (rdata.y == req_reg.y)
                    && (rdata.z == req_reg.z);

    // Memory write selection
    always_comb
    begin
        we    = 1'b0;
        waddr = raddr_last_reg;
        wdata = rdata;
        if (state_reg == ST_CHECK && rvalid_reg)
        begin
            if (op_reg == cdet_pkg::REQ_INSERT && key_eq && !hit_reg)
            begin
                we          = 1'b1;
                waddr       = raddr_last_reg;
                wdata       = rdata;
                wdata.rem   = (rdata.rem > req_reg.rem) ? req_reg.rem : rdata.rem;
                wdata.flags = rdata.flags | req_reg.flags;
            end
            else if (op_reg == cdet_pkg::REQ_TICK && rdata.rem != 16'd0)
            begin
                we       = 1'b1;
                waddr    = kept_reg[AW-1:0];
                wdata    = rdata;
                wdata.rem = rdata.rem - 16'd1;
            end
        end
        else if (state_reg == ST_DONE && op_reg == cdet_pkg::REQ_INSERT
                 && !hit_reg && occ_reg != CW'(TABLE_DEPTH))
        begin
            we    = 1'b1;
            waddr = occ_reg[AW-1:0];
            wdata = req_reg;
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            strobe      <= 1'b0;
            pend_reg    <= 1'b0;
            rvalid_reg  <= 1'b0;
            hit_reg     <= 1'b0;
            emitted_reg <= 1'b0;
            op_reg      <= cdet_pkg::REQ_INSERT;
            rd_reg      <= '0;
            kept_reg    <= '0;
            res_kind    <= cdet_pkg::KIND_IDLE;
            out_x       <= '0;
            out_y       <= '0;
            out_z       <= '0;
            out_flags   <= '0;
            last        <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg        <= req_type;
                        req_reg.x     <= pos_x;
                        req_reg.y     <= pos_y;
                        req_reg.z     <= pos_z;
                        req_reg.rem   <= delay_ticks;
                        req_reg.flags <= event_flags;
                        rd_reg        <= '0;
                        kept_reg      <= '0;
                        hit_reg       <= 1'b0;
                        emitted_reg   <= 1'b0;
                        pend_reg      <= 1'b0;
                        rvalid_reg    <= 1'b0;
                        if (req_type == cdet_pkg::REQ_CLEAR)
                        begin
                            occ_reg   <= '0;
                            strobe    <= 1'b1;
                            res_kind  <= cdet_pkg::KIND_CLEARED;
                            out_x     <= '0;
                            out_y     <= '0;
                            out_z     <= '0;
                            out_flags <= '0;
                            last      <= 1'b1;
                        end
                        else if (req_type == cdet_pkg::REQ_INSERT
                                 || req_type == cdet_pkg::REQ_TICK)
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    // issue reads; the data is checked in the following cycle
                    if (rd_reg < occ_reg)
                    begin
                        rvalid_reg     <= 1'b1;
                        raddr_last_reg <= rd_reg[AW-1:0];
                        rd_reg         <= rd_reg + CW'(1);
                    end
                    else
                    begin
                        rvalid_reg <= 1'b0;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (rvalid_reg)
                    begin
                        if (op_reg == cdet_pkg::REQ_INSERT)
                        begin
                            if (key_eq)
                            begin
                                hit_reg <= 1'b1;
                            end
                        end
                        else if (rdata.rem == 16'd0)
                        begin
                            // emit previous pending, hold this one
                            if (pend_reg)
                            begin
                                strobe    <= 1'b1;
                                res_kind  <= cdet_pkg::KIND_EXPIRED;
                                out_x     <= pend_data_reg.x;
                                out_y     <= pend_data_reg.y;
                                out_z     <= pend_data_reg.z;
                                out_flags <= pend_data_reg.flags;
                                last      <= 1'b0;
                            end
                            pend_reg      <= 1'b1;
                            pend_data_reg <= rdata;
                            emitted_reg   <= 1'b1;
                        end
                        else
                        begin
                            kept_reg <= kept_reg + CW'(1);
                        end
                    end
                    // advance: issue next read or finish
                    if (rd_reg < occ_reg && !(rvalid_reg && op_reg ==
                        cdet_pkg::REQ_INSERT && key_eq))
                    begin
                        rvalid_reg     <= 1'b1;
                        raddr_last_reg <= rd_reg[AW-1:0];
                        rd_reg         <= rd_reg + CW'(1);
                    end
                    else
                    begin
                        rvalid_reg <= 1'b0;
                        if (!rvalid_reg || rd_reg >= occ_reg
                            || (op_reg == cdet_pkg::REQ_INSERT && key_eq))
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    strobe    <= 1'b1;
                    last      <= 1'b1;
                    out_x     <= '0;
                    out_y     <= '0;
                    out_z     <= '0;
                    out_flags <= '0;
                    state_reg <= ST_IDLE;
                    if (op_reg == cdet_pkg::REQ_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            res_kind <= cdet_pkg::KIND_MERGED;
                        end
                        else if (occ_reg == CW'(TABLE_DEPTH))
                        begin
                            res_kind <= cdet_pkg::KIND_DROPPED;
                        end
                        else
                        begin
                            res_kind <= cdet_pkg::KIND_APPENDED;
                            occ_reg  <= occ_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        occ_reg <= kept_reg;
                        if (emitted_reg)
                        begin
                            res_kind  <= cdet_pkg::KIND_EXPIRED;
                            out_x     <= pend_data_reg.x;
                            out_y     <= pend_data_reg.y;
                            out_z     <= pend_data_reg.z;
                            out_flags <= pend_data_reg.flags;
                        end
                        else
                        begin
                            res_kind <= cdet_pkg::KIND_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/cdet_checker.sv
// ----------------------------------------------------------------------------
// cdet_checker
// Port-level checks on the coalescing delay event table.
// ----------------------------------------------------------------------------
module cdet_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       strobe,
    input logic [2:0] res_kind,
    input logic [15:0] out_flags,
    input logic       last
);

    // A clear answers in the next cycle with a single cleared word
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == cdet_pkg::REQ_CLEAR)
        |=> (strobe && last && res_kind == cdet_pkg::KIND_CLEARED))
        else $error("clear not answered");

    // Only expired words may come without last
    a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (res_kind == cdet_pkg::KIND_EXPIRED))
        else $error("non-final word of wrong kind");

    // Status words carry no flags
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res_kind != cdet_pkg::KIND_EXPIRED) |-> (out_flags == 16'd0))
        else $error("status word with flags");

    // Insert and tick hold busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == cdet_pkg::REQ_INSERT
            || req_type == cdet_pkg::REQ_TICK)) |=> busy)
        else $error("busy not raised");

endmodule

bind coalescing_delay_event_table cdet_checker u_cdet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .strobe    (strobe),
    .res_kind  (res_kind),
    .out_flags (out_flags),
    .last      (last)
);
